/* src/tkv_pkg.sv */
package tkv_pkg;

	localparam int DATA_W = 64;

	typedef enum logic [2:0] {
		CMD_SET      = 3'd0,
		CMD_GET      = 3'd1,
		CMD_UNSET    = 3'd2,
		CMD_COUNT    = 3'd3,
		CMD_BEGIN    = 3'd4,
		CMD_COMMIT   = 3'd5,
		CMD_ROLLBACK = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_TXN     = 3'd1,
		ST_TABLE_FULL = 3'd2,
		ST_LOG_FULL   = 3'd3,
		ST_NEST_FULL  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TXN,
		S_ESCAN,
		S_EDEC,
		S_DSCAN,
		S_DWR,
		S_EWR,
		S_ISCAN,
		S_IWR,
		S_QSCAN,
		S_LCHK,
		S_LWAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] data_value;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] read_value;
		logic [6:0]        match_count;
		logic [2:0]        status;
	} rsp_t;

endpackage

/* src/transactional_key_value_table.sv */
// Transactional key-value table. Raise start with a request on req while busy is low; the
// request is taken at that edge and busy rises. Exactly one response follows: rsp is valid
// for the single cycle in which done is high, and the receiver must take it then, as the
// block cannot hold it back. Every key or count lookup is a linear scan of a one-port
// synchronous memory, one entry per cycle. Get, unset-miss and count equal each run one scan;
// a set runs up to three scans (key, old value count, new value count) and an unset up to
// two (key, old value count); begin and commit run no scan. Rollback adds, for each undone
// log record, a log read (S_LCHK, S_LWAIT) and up to three scans. No clearing pass follows
// reset.
module transactional_key_value_table
	import tkv_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64,
	parameter int LOG_DEPTH     = 256,
	parameter int MAX_NESTING   = 16,
	parameter int KEY_BITS      = 64,
	parameter int VALUE_BITS    = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int LW = $clog2(LOG_DEPTH);
	localparam int TW = $clog2(LOG_DEPTH + 1);
	localparam int NW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
	localparam int DW = $clog2(MAX_NESTING + 1);
	localparam int KB = KEY_BITS;
	localparam int VB = VALUE_BITS;

	state_t st_q, st_d;

	logic [2:0]    cmd_q;
	logic [KB-1:0] wk_q;
	logic [VB-1:0] wv_q;
	logic [VB-1:0] cs_q;
	logic          rb_q;
	logic          pv_q;
	rsp_t          res_q;

	logic [IW:0]   sc_q;
	logic          rv_s1;
	logic [IW-1:0] ri_s1;

	logic [KB+VB-1:0]   ent_mem [TABLE_ENTRIES];
	logic [KB+VB-1:0]   ent_rd_s1;
	logic [TABLE_ENTRIES-1:0] ent_vld_q;
	logic          hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [VB-1:0] hit_val_q;

	logic [VB+CW-1:0]   cnt_mem [TABLE_ENTRIES];
	logic [VB+CW-1:0]   cnt_rd_s1;
	logic [TABLE_ENTRIES-1:0] cnt_live_q;
	logic          chit_q, cfree_q;
	logic [IW-1:0] chit_idx_q, cfree_idx_q;
	logic [CW-1:0] ccnt_q;

	logic [KB+VB:0] log_mem [LOG_DEPTH];
	logic [KB+VB:0] log_rd_s1;
	logic [TW-1:0]  top_q, top_m1, mk_q;
	logic [TW-1:0]  mark_q [MAX_NESTING];
	logic [DW-1:0]  depth_q, depth_m1;

	logic [KB-1:0] req_key;
	logic [VB-1:0] req_val;
	logic in_txn, log_full, is_store;
	logic scan_e, scan_c, issue, last;
	logic ent_init, cnt_init;
	logic accept, push, ent_wr, ent_clr, cnt_dec, cnt_inc, set_found, st_we;
	logic [2:0] st_code;
	state_t fin_st;

	assign req_key  = req.key[KB-1:0];
	assign req_val  = req.data_value[VB-1:0];
	assign in_txn   = depth_q != '0;
	assign log_full = top_q == TW'(LOG_DEPTH);
	assign is_store = rb_q ? pv_q : (cmd_q == CMD_SET);
	assign top_m1   = top_q - TW'(1);
	assign depth_m1 = depth_q - DW'(1);
	assign fin_st   = rb_q ? S_LCHK : S_DONE;

	assign scan_e = st_q == S_ESCAN;
	assign scan_c = (st_q == S_DSCAN) || (st_q == S_ISCAN) || (st_q == S_QSCAN);
	assign issue  = (scan_e || scan_c) && (sc_q < (IW+1)'(TABLE_ENTRIES));
	assign last   = rv_s1 && (ri_s1 == IW'(TABLE_ENTRIES - 1));

	assign ent_init = (st_d == S_ESCAN) && (st_q != S_ESCAN);
	assign cnt_init = ((st_d == S_DSCAN) || (st_d == S_ISCAN) || (st_d == S_QSCAN))
		&& (st_d != st_q);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (start) begin
					unique case (req.cmd)
						CMD_SET:             st_d = (req_key == '0) ? S_DONE : S_ESCAN;
						CMD_GET, CMD_UNSET:  st_d = S_ESCAN;
						CMD_COUNT:           st_d = S_QSCAN;
						default:             st_d = S_TXN;
					endcase
				end
			end
			S_TXN: st_d = ((cmd_q == CMD_ROLLBACK) && in_txn) ? S_LCHK : S_DONE;
			S_ESCAN: if (last) st_d = S_EDEC;
			S_EDEC: begin
				if (rb_q) begin
					if (hit_q)
						st_d = S_DSCAN;
					else if (pv_q && free_q)
						st_d = S_EWR;
					else
						st_d = S_LCHK;
				end else begin
					unique case (cmd_q)
						CMD_SET: begin
							if ((in_txn && log_full) || (!hit_q && !free_q))
								st_d = S_DONE;
							else
								st_d = hit_q ? S_DSCAN : S_EWR;
						end
						CMD_UNSET: st_d = (hit_q && !(in_txn && log_full)) ? S_DSCAN : S_DONE;
						default:   st_d = S_DONE;
					endcase
				end
			end
			S_DSCAN: if (last) st_d = S_DWR;
			S_DWR:   st_d = is_store ? S_EWR : fin_st;
			S_EWR:   st_d = S_ISCAN;
			S_ISCAN: if (last) st_d = S_IWR;
			S_IWR:   st_d = fin_st;
			S_QSCAN: if (last) st_d = S_DONE;
			S_LCHK:  st_d = (top_q > mk_q) ? S_LWAIT : S_DONE;
			S_LWAIT: st_d = S_ESCAN;
			S_DONE:  st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		accept    = (st_q == S_IDLE) && start;
		push      = 1'b0;
		set_found = 1'b0;
		st_we     = 1'b0;
		st_code   = ST_OK;
		ent_wr    = st_q == S_EWR;
		ent_clr   = (st_q == S_DWR) && !is_store;
		cnt_dec   = (st_q == S_DWR) && chit_q;
		cnt_inc   = st_q == S_IWR;
		unique case (st_q)
			S_EDEC: begin
				if (!rb_q) begin
					unique case (cmd_q)
						CMD_SET: begin
							st_we = 1'b1;
							if (in_txn && log_full)
								st_code = ST_LOG_FULL;
							else if (!hit_q && !free_q)
								st_code = ST_TABLE_FULL;
							else
								push = in_txn;
						end
						CMD_GET: set_found = hit_q;
						CMD_UNSET: begin
							if (hit_q && in_txn && log_full) begin
								st_we   = 1'b1;
								st_code = ST_LOG_FULL;
							end else begin
								set_found = hit_q;
								push      = hit_q && in_txn;
							end
						end
						default: ;
					endcase
				end
			end
			S_TXN: begin
				st_we = 1'b1;
				unique case (cmd_q)
					CMD_BEGIN:
						st_code = (depth_q >= DW'(MAX_NESTING)) ? ST_NEST_FULL : ST_OK;
					CMD_COMMIT, CMD_ROLLBACK:
						st_code = in_txn ? ST_OK : ST_NO_TXN;
					default: st_code = ST_OK;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			top_q   <= '0;
			depth_q <= '0;
			rb_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (accept)
				rb_q <= 1'b0;
			if (push)
				top_q <= top_q + TW'(1);
			if (st_q == S_LCHK && top_q > mk_q)
				top_q <= top_m1;
			if (st_q == S_TXN) begin
				unique case (cmd_q)
					CMD_BEGIN:
						if (depth_q < DW'(MAX_NESTING))
							depth_q <= depth_q + DW'(1);
					CMD_COMMIT:
						if (in_txn) begin
							depth_q <= '0;
							top_q   <= '0;
						end
					CMD_ROLLBACK:
						if (in_txn) begin
							depth_q <= depth_m1;
							rb_q    <= 1'b1;
						end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			wk_q  <= req_key;
			wv_q  <= req_val;
			res_q <= '0;
		end
		if (set_found) begin
			res_q.found      <= 1'b1;
			res_q.read_value <= (cmd_q == CMD_GET) ? DATA_W'(hit_val_q) : '0;
		end
		if (st_we)
			res_q.status <= st_code;
		if (st_q == S_QSCAN && last)
			res_q.match_count <= (chit_q || (rv_s1 && cnt_live_q[ri_s1]
				&& cnt_rd_s1[VB+CW-1:CW] == cs_q)) ?
				7'(chit_q ? ccnt_q : cnt_rd_s1[CW-1:0]) : 7'd0;
		unique case (st_q)
			S_IDLE:  cs_q <= req_val;
			S_EDEC:  cs_q <= hit_val_q;
			S_EWR:   cs_q <= wv_q;
			default: ;
		endcase
		if (st_q == S_TXN && cmd_q == CMD_BEGIN && depth_q < DW'(MAX_NESTING))
			mark_q[depth_q[NW-1:0]] <= top_q;
		if (st_q == S_TXN)
			mk_q <= mark_q[depth_m1[NW-1:0]];
		if (st_q == S_LWAIT) begin
			pv_q <= log_rd_s1[KB+VB];
			wk_q <= log_rd_s1[KB+VB-1:VB];
			wv_q <= log_rd_s1[VB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= sc_q[IW-1:0];
		if (ent_init || cnt_init)
			sc_q <= '0;
		else if (issue)
			sc_q <= sc_q + (IW+1)'(1);
		if (ent_init) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (scan_e && rv_s1) begin
			if (!hit_q && ent_vld_q[ri_s1] && wk_q != '0
				&& ent_rd_s1[KB+VB-1:VB] == wk_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= ri_s1;
				hit_val_q <= ent_rd_s1[VB-1:0];
			end
			if (!free_q && !ent_vld_q[ri_s1]) begin
				free_q     <= 1'b1;
				free_idx_q <= ri_s1;
			end
		end
		if (cnt_init) begin
			chit_q  <= 1'b0;
			cfree_q <= 1'b0;
		end else if (scan_c && rv_s1) begin
			if (!chit_q && cnt_live_q[ri_s1] && cnt_rd_s1[VB+CW-1:CW] == cs_q) begin
				chit_q     <= 1'b1;
				chit_idx_q <= ri_s1;
				ccnt_q     <= cnt_rd_s1[CW-1:0];
			end
			if (!cfree_q && !cnt_live_q[ri_s1]) begin
				cfree_q     <= 1'b1;
				cfree_idx_q <= ri_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_rd_s1 <= ent_mem[sc_q[IW-1:0]];
		if (ent_wr)
			ent_mem[hit_q ? hit_idx_q : free_idx_q] <= {wk_q, wv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (ent_wr) begin
			ent_vld_q[hit_q ? hit_idx_q : free_idx_q] <= 1'b1;
		end else if (ent_clr) begin
			ent_vld_q[hit_idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cnt_rd_s1 <= cnt_mem[sc_q[IW-1:0]];
		if (cnt_dec)
			cnt_mem[chit_idx_q] <= {cs_q, ccnt_q - CW'(1)};
		else if (cnt_inc)
			cnt_mem[chit_q ? chit_idx_q : cfree_idx_q] <=
				{cs_q, chit_q ? ccnt_q + CW'(1) : CW'(1)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_live_q <= '0;
		end else if (cnt_dec && ccnt_q == CW'(1)) begin
			cnt_live_q[chit_idx_q] <= 1'b0;
		end else if (cnt_inc && !chit_q) begin
			cnt_live_q[cfree_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		log_rd_s1 <= log_mem[top_m1[LW-1:0]];
		if (push)
			log_mem[top_q[LW-1:0]] <= {hit_q, wk_q, hit_q ? hit_val_q : VB'(0)};
	end

	assign busy = st_q != S_IDLE;
	assign done = st_q == S_DONE;
	assign rsp  = res_q;

endmodule

/* src/tkv_chk.sv */
module tkv_chk
	import tkv_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request not held busy");

	a_req_known: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !$isunknown(req))
		else $error("unknown request taken");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (busy ##1 !busy && !done))
		else $error("response not followed by idle");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_NO_TXN
			|| rsp.status == ST_TABLE_FULL || rsp.status == ST_LOG_FULL
			|| rsp.status == ST_NEST_FULL))
		else $error("bad status");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.found) |-> (rsp.status == ST_OK && rsp.match_count == 7'd0))
		else $error("found with error or count");

endmodule

bind transactional_key_value_table tkv_chk u_tkv_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
